// ----- rtl/core/padded_integer_to_ascii_unit_assert.svh -----
// assertion macros shared by the formatting unit
// clock and reset are taken from the module that uses them
`ifndef PADDED_INTEGER_TO_ASCII_UNIT_ASSERT_SVH
`define PADDED_INTEGER_TO_ASCII_UNIT_ASSERT_SVH

// same-cycle implication
`define PIA_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pia assertion failed");

// next-cycle implication
`define PIA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pia assertion failed");

`endif

// ----- rtl/core/pia_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pia_pkg;

    localparam int VALUE_W  = 32;
    localparam int FW_W     = 6;
    localparam int PREC_W   = 6;
    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 4;
    // counts up to 127 characters
    localparam int LEN_W    = 7;

    localparam logic [PREC_W-1:0] PREC_MAX = PREC_W'(48);

    localparam logic OP_DEC = 1'b0;
    localparam logic OP_HEX = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    // 'a' minus ten
    localparam logic [CHAR_W-1:0] CHAR_HEX_OFS = 8'd87;

    localparam logic [DIGIT_W-1:0] DEC_LAST = 4'd9;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = CHAR_W'(d);
        return (d <= DEC_LAST) ? (ext + CHAR_ZERO) : (ext + CHAR_HEX_OFS);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pia_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pia_in_if import pia_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [VALUE_W-1:0] value;
    logic [FW_W-1:0]   field_width;
    logic              has_precision;
    logic [PREC_W-1:0] precision;

    modport source (
        output valid, opcode, value, field_width, has_precision, precision,
        input  ready
    );
    modport sink (
        input  valid, opcode, value, field_width, has_precision, precision,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/pia_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pia_out_if import pia_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last_char;

    modport source (output valid, out_char, last_char, input ready);
    modport sink (input valid, out_char, last_char, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pia_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none

// one digit step: quotient and remainder by 10 or 16
// product is registered, results are valid in the cycle after i_mag settles
module pia_divider import pia_pkg::*; #(
    parameter int MAG_W = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_hex,
    input  wire logic [MAG_W-1:0]   i_mag,
    output logic      [MAG_W-1:0]   o_quot,
    output logic      [DIGIT_W-1:0] o_rem
);

    localparam int PW = MAG_W + 32;
    // ceil(2^35 / 10), exact for every 32-bit dividend
    localparam logic [PW-1:0] RECIP_10 = PW'(32'hcccc_cccd);
    localparam int RECIP_SHIFT = 35;

    logic [PW-1:0]    r_prod;
    logic [MAG_W-1:0] w_q10;
    logic [MAG_W-1:0] w_r10;

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_mag) * RECIP_10;
    end

    assign w_q10  = MAG_W'(r_prod >> RECIP_SHIFT);
    assign w_r10  = i_mag - (w_q10 << 3) - (w_q10 << 1);
    assign o_quot = i_hex ? (i_mag >> 4) : w_q10;
    assign o_rem  = i_hex ? i_mag[DIGIT_W-1:0] : w_r10[DIGIT_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/padded_integer_to_ascii_unit.sv -----
// sequence: per digit a multiply state then a digit state (up to 10 decimal, 8 hex), then the length math,
//   then one character per cycle while the output side takes them
// a new request is taken only once the last character of the current one has been loaded
// the digit loop runs through the shared multiply-by-reciprocal unit, one digit per pass
// reset: synchronous active-low i_rst_n returns the sequencer to idle, output empty
`timescale 1ns / 1ps
`default_nettype none

`include "padded_integer_to_ascii_unit_assert.svh"

module padded_integer_to_ascii_unit import pia_pkg::*; #(
    parameter int MAX_WIDTH  = 60,
    parameter int VALUE_BITS = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pia_in_if.sink    i_in,
    pia_out_if.source o_out
);

    // value bits that survive the 32-bit port and the configured width
    localparam int MAG_W     = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    // a sign bit only exists when it lies inside the port
    localparam bit SIGN_EN   = (VALUE_BITS <= VALUE_W);
    // decimal digits of 2^MAG_W - 1 (log10(2) ~ 0.30103), also covers hex
    localparam int DIG_DEPTH = (MAG_W * 30103) / 100000 + 1;
    localparam int DIG_AW    = $clog2(DIG_DEPTH);
    localparam int CNT_W     = $clog2(DIG_DEPTH + 1);
    localparam logic [LEN_W-1:0] W_MAX = LEN_W'(MAX_WIDTH);

    // sequencer: capture, then alternate multiply / digit unless skipped, then lengths, then emit if any
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIG  = 5'b00100,
        S_CALC = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // request fields captured at acceptance; r_mag and r_neg are consumed as the item runs
    logic               r_hex;
    logic [MAG_W-1:0]   r_mag;
    logic               r_neg;
    logic [LEN_W-1:0]   r_width;
    logic [PREC_W-1:0]  r_prec;

    // digit store, least significant first, no reset needed
    logic [DIGIT_W-1:0] r_digits [DIG_DEPTH];
    logic [CNT_W-1:0]   r_ndig;
    logic [CNT_W-1:0]   r_didx;

    // emission counters
    logic [LEN_W-1:0]   r_spaces;
    logic [LEN_W-1:0]   r_zeros;
    logic [LEN_W-1:0]   r_left;

    // output register
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;

    // capture path
    logic               w_accept;
    logic [MAG_W-1:0]   w_v;
    logic               w_neg;
    logic [MAG_W-1:0]   w_mag;
    logic [LEN_W-1:0]   w_fw;
    logic [LEN_W-1:0]   w_w;
    logic [PREC_W-1:0]  w_p;
    logic               w_skip;

    // shared digit unit
    logic [MAG_W-1:0]   w_quot;
    logic [DIGIT_W-1:0] w_rem;

    // length math
    logic [LEN_W-1:0]   w_ndig_l;
    logic [LEN_W-1:0]   w_prec_l;
    logic [LEN_W-1:0]   w_zeros;
    logic [LEN_W-1:0]   w_body;
    logic [LEN_W-1:0]   w_spaces;
    logic [LEN_W-1:0]   w_total;

    // emission
    logic               w_load;
    logic [CNT_W-1:0]   w_didx_m1;
    logic [CHAR_W-1:0]  w_char;

    assign i_in.ready     = (r_state == S_IDLE);
    assign w_accept       = i_in.valid && i_in.ready;

    assign o_out.valid     = r_out_valid;
    assign o_out.out_char  = r_char;
    assign o_out.last_char = r_last;

    // --- request capture: sign, magnitude and saturated lengths ---
    assign w_v   = i_in.value[MAG_W-1:0];
    assign w_neg = SIGN_EN && (i_in.opcode == OP_DEC) && w_v[MAG_W-1];
    // two's complement negate; the most negative value maps to its own bits,
    // which is already the right unsigned magnitude
    assign w_mag = w_neg ? (~w_v + MAG_W'(1)) : w_v;
    assign w_fw  = LEN_W'(i_in.field_width);
    assign w_w   = (w_fw > W_MAX) ? W_MAX : w_fw;

    always_comb begin
        priority if (!i_in.has_precision) begin
            w_p = '0;
        end else if (i_in.precision > PREC_MAX) begin
            w_p = PREC_MAX;
        end else begin
            w_p = i_in.precision;
        end
    end

    // zero value with an explicit zero precision prints no digits at all
    assign w_skip = (w_mag == '0) && i_in.has_precision && (i_in.precision == '0);

    // --- shared digit unit, product registered inside ---
    pia_divider #(
        .MAG_W (MAG_W)
    ) u_divider (
        .i_clk  (i_clk),
        .i_hex  (r_hex),
        .i_mag  (r_mag),
        .o_quot (w_quot),
        .o_rem  (w_rem)
    );

    // --- lengths: zeros count toward the width, spaces fill the rest ---
    assign w_ndig_l = LEN_W'(r_ndig);
    assign w_prec_l = LEN_W'(r_prec);
    assign w_zeros  = (w_prec_l > w_ndig_l) ? (w_prec_l - w_ndig_l) : '0;
    assign w_body   = LEN_W'(r_neg) + w_zeros + w_ndig_l;
    assign w_spaces = (r_width > w_body) ? (r_width - w_body) : '0;
    assign w_total  = w_spaces + w_body;

    // --- emission: spaces, sign, zeros, digits most significant first ---
    // a new character loads when the output register is empty or being drained
    assign w_load    = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);
    assign w_didx_m1 = r_didx - CNT_W'(1);

    always_comb begin
        priority if (r_spaces != '0) begin
            w_char = CHAR_SPACE;
        end else if (r_neg) begin
            w_char = CHAR_MINUS;
        end else if (r_zeros != '0) begin
            w_char = CHAR_ZERO;
        end else begin
            w_char = digit_char(r_digits[w_didx_m1[DIG_AW-1:0]]);
        end
    end

    // --- sequencer ---
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_skip ? S_CALC : S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_DIG;
            end
            S_DIG: begin
                // do-while: at least one digit unless skipped at capture
                n_state = (w_quot == '0) ? S_CALC : S_MUL;
            end
            S_CALC: begin
                n_state = (w_total == '0) ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                if (w_load && (r_left == LEN_W'(1))) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath, gated by the sequencer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hex   <= i_in.opcode;
            r_mag   <= w_mag;
            r_neg   <= w_neg;
            r_width <= w_w;
            r_prec  <= w_p;
            r_ndig  <= '0;
        end
        if (r_state == S_DIG) begin
            r_digits[r_ndig[DIG_AW-1:0]] <= w_rem;
            r_ndig <= r_ndig + CNT_W'(1);
            r_mag  <= w_quot;
        end
        if (r_state == S_CALC) begin
            r_spaces <= w_spaces;
            r_zeros  <= w_zeros;
            r_left   <= w_total;
            r_didx   <= r_ndig;
        end
        if (w_load) begin
            r_char <= w_char;
            r_last <= (r_left == LEN_W'(1));
            r_left <= r_left - LEN_W'(1);
            priority if (r_spaces != '0) begin
                r_spaces <= r_spaces - LEN_W'(1);
            end else if (r_neg) begin
                r_neg <= 1'b0;
            end else if (r_zeros != '0) begin
                r_zeros <= r_zeros - LEN_W'(1);
            end else begin
                r_didx <= w_didx_m1;
            end
        end
    end

    // --- checks ---
    // digit count never runs past the store
    `PIA_ASSERT(a_ndig_bound, r_state == S_DIG, r_ndig < CNT_W'(DIG_DEPTH))
    // decimal remainders stay within one decimal digit
    `PIA_ASSERT(a_dec_digit, (r_state == S_DIG) && !r_hex, w_rem <= DEC_LAST)
    // emission never runs with nothing left to send
    `PIA_ASSERT(a_emit_left, r_state == S_EMIT, r_left != '0)
    // loading the final character flags it and frees the sequencer
    `PIA_ASSERT_NEXT(a_last_done, w_load && (r_left == LEN_W'(1)),
                     (r_state == S_IDLE) && r_out_valid && r_last)

endmodule

`default_nettype wire

// ----- bench/pia_format_checker.sv -----
`timescale 1ns / 1ps

// watches the request and character channels, predicts the padded text
// of every accepted request and compares each accepted character in order
module pia_format_checker import pia_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    pia_in_if    i_req_mon,
    pia_out_if   i_chr_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_chars_checked
);

    localparam int FIELD_MAX   = 60;
    localparam int REPORT_MAX  = 50;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } ascii_char_t;

    ascii_char_t expected_chars[$];
    int          mismatches;
    int          chars_checked;

    assign o_fail_count    = mismatches;
    assign o_chars_checked = chars_checked;

    task automatic report_mismatch(input string what);
        if (mismatches < REPORT_MAX)
            $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // builds the character sequence of one request and queues it
    function automatic void format_request(
        input logic               op,
        input logic [VALUE_W-1:0] val,
        input logic [FW_W-1:0]    fw,
        input logic               prec_given,
        input logic [PREC_W-1:0]  prec
    );
        logic [VALUE_W-1:0] mag;
        logic               neg;
        int unsigned        width_eff, prec_eff, radix, ndig, zeros, body, spaces, i;
        logic [DIGIT_W-1:0] digits [0:9];
        ascii_char_t        line[$];
        ascii_char_t        c;

        width_eff = (int'(fw) > FIELD_MAX) ? FIELD_MAX : fw;
        if (!prec_given)
            prec_eff = 0;
        else
            prec_eff = (prec > PREC_MAX) ? PREC_MAX : prec;
        radix = (op == OP_HEX) ? 16 : 10;
        neg   = (op == OP_DEC) && val[VALUE_W-1];
        mag   = neg ? -val : val;

        // an explicit zero precision swallows a zero value entirely
        ndig = 0;
        if (!(mag == '0 && prec_given && prec_eff == 0)) begin
            do begin
                digits[ndig] = DIGIT_W'(mag % radix);
                ndig++;
                mag = mag / radix;
            end while (mag != '0);
        end

        zeros  = (prec_eff > ndig) ? prec_eff - ndig : 0;
        body   = (neg ? 1 : 0) + zeros + ndig;
        spaces = (width_eff > body) ? width_eff - body : 0;

        c.last = 1'b0;
        c.ch   = CHAR_SPACE;
        for (i = 0; i < spaces; i++) line.push_back(c);
        c.ch = CHAR_MINUS;
        if (neg) line.push_back(c);
        c.ch = CHAR_ZERO;
        for (i = 0; i < zeros; i++) line.push_back(c);
        for (i = ndig; i > 0; i--) begin
            if (digits[i-1] < 4'd10)
                c.ch = CHAR_ZERO + CHAR_W'(digits[i-1]);
            else
                c.ch = 8'h61 + CHAR_W'(digits[i-1]) - 8'd10;
            line.push_back(c);
        end

        if (line.size() > 0)
            line[line.size()-1].last = 1'b1;
        foreach (line[k]) expected_chars.push_back(line[k]);
    endfunction

    always @(posedge i_clk) begin
        ascii_char_t want;
        if (i_rst_n) begin
            // compare before queueing: a character never belongs to a request
            // accepted at the same edge
            if (i_chr_mon.valid && i_chr_mon.ready) begin
                chars_checked++;
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected character %0h, last %0b",
                                              i_chr_mon.out_char, i_chr_mon.last_char));
                end else begin
                    want = expected_chars.pop_front();
                    if (i_chr_mon.out_char !== want.ch)
                        report_mismatch($sformatf("out_char %0h, expected %0h",
                                                  i_chr_mon.out_char, want.ch));
                    if (i_chr_mon.last_char !== want.last)
                        report_mismatch($sformatf("last_char %0b, expected %0b on char %0h",
                                                  i_chr_mon.last_char, want.last, want.ch));
                end
            end
            if (i_req_mon.valid && i_req_mon.ready)
                format_request(i_req_mon.opcode, i_req_mon.value, i_req_mon.field_width,
                               i_req_mon.has_precision, i_req_mon.precision);
        end
        o_pending <= expected_chars.size();
    end

endmodule

// ----- bench/tb_padded_integer_to_ascii_unit.sv -----
`timescale 1ns / 1ps

// drives formatting requests into the unit, throttles the character side,
// and gives the verdict from the checker's mismatch count and pending backlog
module tb_padded_integer_to_ascii_unit;
    import pia_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 450;
    // final stretch of the run with neither side idling
    localparam int QUIET_ITEMS  = 60;
    // worst quiet gap: sender gap + digit loop + receiver stall, taken many times
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 64;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic quiet;

    pia_in_if  req_bus ();
    pia_out_if chr_bus ();

    int fail_count, pending_chars, chars_checked;
    int requests_sent;
    int gap_pct;
    int stall_pct   = 20;
    int burst_left  = 0;
    int mode_cycles = 0;
    int idle_cycles = 0;

    always #HALF_PERIOD i_clk = ~i_clk;

    padded_integer_to_ascii_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_bus),
        .o_out   (chr_bus)
    );

    pia_format_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_mon       (req_bus),
        .i_chr_mon       (chr_bus),
        .o_fail_count    (fail_count),
        .o_pending       (pending_chars),
        .o_chars_checked (chars_checked)
    );

    // character side: ready runs and stall bursts, stall rate changes over time
    always @(posedge i_clk) begin
        mode_cycles++;
        if (mode_cycles >= 256) begin
            mode_cycles = 0;
            case ($urandom_range(2))
                0: stall_pct = 0;
                1: stall_pct = 20;
                default: stall_pct = 50;
            endcase
        end
        if (quiet) begin
            chr_bus.ready <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left--;
        end else if ($urandom_range(99) < stall_pct) begin
            chr_bus.ready <= 1'b0;
            burst_left = $urandom_range(1, 14) - 1;
        end else begin
            chr_bus.ready <= 1'b1;
            burst_left = $urandom_range(1, 20) - 1;
        end
    end

    // watchdog on cycles where neither channel moves anything
    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (chr_bus.valid && chr_bus.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == STALL_LIMIT) begin
            $display("timeout: %0d cycles without a transfer", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_request(
        input logic               op,
        input logic [VALUE_W-1:0] val,
        input logic [FW_W-1:0]    fw,
        input logic               prec_given,
        input logic [PREC_W-1:0]  prec
    );
        if (!quiet && $urandom_range(99) < gap_pct) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.opcode        <= op;
        req_bus.value         <= val;
        req_bus.field_width   <= fw;
        req_bus.has_precision <= prec_given;
        req_bus.precision     <= prec;
        do @(posedge i_clk); while (!req_bus.ready);
        requests_sent++;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(5))
            0: v = $urandom;
            1: v = $urandom_range(0, 99);
            2: v = -VALUE_W'($urandom_range(1, 999));
            3: v = $urandom >> $urandom_range(0, 31);
            4: v = ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: v = '0;
        endcase
        return v;
    endfunction

    task automatic send_random_request();
        logic [FW_W-1:0]   fw;
        logic [PREC_W-1:0] prec;
        logic              op;
        // mostly short fields, now and then the full range including saturation
        case ($urandom_range(9))
            0: fw = FW_W'($urandom_range(0, 63));
            1, 2: fw = FW_W'($urandom_range(0, 40));
            default: fw = FW_W'($urandom_range(0, 16));
        endcase
        case ($urandom_range(7))
            0: prec = PREC_W'($urandom_range(0, 63));
            1, 2: prec = '0;
            default: prec = PREC_W'($urandom_range(0, 12));
        endcase
        op = ($urandom_range(1) != 0) ? OP_HEX : OP_DEC;
        send_request(op, pick_value(), fw, 1'($urandom_range(1)), prec);
    endtask

    initial begin
        req_bus.valid         <= 1'b0;
        req_bus.opcode        <= OP_DEC;
        req_bus.value         <= '0;
        req_bus.field_width   <= '0;
        req_bus.has_precision <= 1'b0;
        req_bus.precision     <= '0;
        i_rst_n               <= 1'b0;
        quiet         = 1'b0;
        gap_pct       = 30;
        requests_sent = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero value: plain, swallowed by zero precision, spaces only
        send_request(OP_DEC, 32'd0, 6'd0, 1'b0, 6'd0);
        send_request(OP_DEC, 32'd0, 6'd0, 1'b1, 6'd0);
        send_request(OP_DEC, 32'd0, 6'd5, 1'b1, 6'd0);
        send_request(OP_HEX, 32'd0, 6'd0, 1'b1, 6'd0);
        send_request(OP_HEX, 32'd0, 6'd3, 1'b0, 6'd0);
        // precision field ignored when absent
        send_request(OP_DEC, 32'd7, 6'd0, 1'b0, 6'd20);
        // decimal extremes, most negative included
        send_request(OP_DEC, 32'h7fff_ffff, 6'd0, 1'b0, 6'd0);
        send_request(OP_DEC, 32'h8000_0000, 6'd0, 1'b0, 6'd0);
        send_request(OP_DEC, 32'hffff_ffff, 6'd4, 1'b0, 6'd0);
        send_request(OP_DEC, 32'h8000_0000, 6'd15, 1'b1, 6'd12);
        // hex extremes, digits a-f
        send_request(OP_HEX, 32'hffff_ffff, 6'd0, 1'b0, 6'd0);
        send_request(OP_HEX, 32'hdead_beef, 6'd20, 1'b1, 6'd12);
        send_request(OP_HEX, 32'h0123_abcd, 6'd2, 1'b1, 6'd1);
        // zeros count toward the width, width smaller than the body
        send_request(OP_DEC, 32'd12345, 6'd10, 1'b1, 6'd7);
        send_request(OP_DEC, -32'd42, 6'd2, 1'b1, 6'd4);
        // width and precision saturation
        send_request(OP_DEC, 32'd1, 6'd63, 1'b0, 6'd0);
        send_request(OP_HEX, 32'h1, 6'd60, 1'b1, 6'd63);
        send_request(OP_DEC, 32'hffff_fffe, 6'd63, 1'b1, 6'd48);
        send_request(OP_DEC, 32'd9, 6'd0, 1'b1, 6'd49);
        send_request(OP_HEX, 32'hffff_ffff, 6'd63, 1'b1, 6'd63);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(2))
                    0: gap_pct = 0;
                    1: gap_pct = 30;
                    default: gap_pct = 70;
                endcase
            end
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            send_random_request();
        end
        req_bus.valid <= 1'b0;

        // let the checker queue the last request before looking at the backlog
        @(posedge i_clk);
        while (pending_chars != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests, %0d characters checked", requests_sent, chars_checked);
        $display("decimal and hex, zero and extreme values, width and precision saturation");
        if (fail_count == 0 && pending_chars == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
